// ===== sv/hpr_pkg.sv =====
// Package for the horizontal polyphase resampler.
// Holds sizes, opcodes, register indexes, state and control types.
// No dependencies; every other file depends on it.
package hpr_pkg;

	// Sizes of the stores and the arithmetic.
	localparam int MAX_TAPS    = 8;
	localparam int ROW_LENGTH  = 4096;
	localparam int COEFF_WIDTH = 16;
	localparam int PHASES      = 256;
	localparam int BANK_DEPTH  = PHASES * MAX_TAPS;
	localparam int BANK_AW     = $clog2(BANK_DEPTH);
	localparam int ROW_AW      = $clog2(ROW_LENGTH);
	localparam int TAPS_W      = $clog2(MAX_TAPS + 1);
	localparam int PROD_W      = COEFF_WIDTH + 9;
	localparam int ACC_W       = PROD_W + $clog2(MAX_TAPS) + 1;
	localparam int FRAC_BITS   = 14;
	localparam int ROUND_INIT  = 'h2000;

	// Field widths of the channels and the register port.
	localparam int ADDR_W  = 12;
	localparam int PIX_W   = 24;
	localparam int POS_W   = 28;
	localparam int STEP_W  = 24;
	localparam int OWID_W  = 13;
	localparam int CNT_W   = 12;
	localparam int PADDR_W = 4;

	typedef enum logic [1:0] {
		OP_LOAD_COEFF = 2'd0,
		OP_LOAD_PIXEL = 2'd1,
		OP_SET_POS    = 2'd2,
		OP_EMIT       = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		REG_TAPS      = 2'd0,
		REG_STEP      = 2'd1,
		REG_OUT_WIDTH = 2'd2,
		REG_NONE      = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT
	} state_t;

	// Control that travels with one tap from the sequencer to the MAC.
	typedef struct packed {
		logic start;
		logic valid;
		logic first;
		logic last;
	} mac_ctl_t;

endpackage

// ===== sv/hpr_if.sv =====
// Handshake channels of the resampler: command items in, pixel items out.
// Depends on hpr_pkg for field widths and the opcode type.
interface hpr_cmd_if;
	logic                                    valid;
	logic                                    ready;
	hpr_pkg::opcode_t                        opcode;
	logic [hpr_pkg::ADDR_W-1:0]              address;
	logic signed [15:0]                      coefficient;
	logic [hpr_pkg::PIX_W-1:0]               pixel_in;
	logic [hpr_pkg::POS_W-1:0]               position;

	modport source (output valid, opcode, address, coefficient, pixel_in, position,
		input ready);
	modport sink (input valid, opcode, address, coefficient, pixel_in, position,
		output ready);
endinterface

interface hpr_res_if;
	logic                        valid;
	logic                        ready;
	logic [hpr_pkg::PIX_W-1:0]   pixel_out;
	logic                        row_end;

	modport source (output valid, pixel_out, row_end, input ready);
	modport sink (input valid, pixel_out, row_end, output ready);
endinterface

// ===== sv/horizontal_polyphase_resampler_unit.sv =====
// Top level of the horizontal polyphase resampler.
// Depends on hpr_pkg, the channels in hpr_if and the MAC in hpr_mac.

// Load, pixel-load and set-position items are taken in the idle state. For an
// emit item the sequencer reads one source pixel and one coefficient per cycle
// from the row store and coefficient bank, then two register stages multiply
// and accumulate, and the clamped pixel is loaded into the output register. The
// output register lets load items flow while a result waits; a second emit
// waits only if that result is still not taken. Both stores are undefined until
// written and need no clearing pass.
module horizontal_polyphase_resampler_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	hpr_cmd_if.sink                      cmd,
	hpr_res_if.source                    res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hpr_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import hpr_pkg::*;

	// Configuration registers.
	logic [3:0]        taps_q;
	logic [STEP_W-1:0] step_q;
	logic [OWID_W-1:0] out_width_q;
	reg_index_t        reg_idx;
	logic              cfg_wr;

	// Block state and per-item sequencing.
	logic [POS_W-1:0]   pos_q;
	logic [CNT_W-1:0]   count_q;
	state_t             state_q, state_d;
	logic [TAPS_W-1:0]  nt_q, k_q, nt_d;
	logic [ROW_AW-1:0]  base_q;
	logic [BANK_AW-1:0] cbase_q;
	logic               row_end_pend_q;

	// Memories and their ports.
	logic [PIX_W-1:0]             row_mem [ROW_LENGTH];
	logic [COEFF_WIDTH-1:0]       coeff_mem [BANK_DEPTH];
	logic [PIX_W-1:0]             pix_rd_s1;
	logic [COEFF_WIDTH-1:0]       coeff_rd_s1;
	logic                         row_we, coeff_we;
	logic [ROW_AW-1:0]            row_wa, row_ra;
	logic [BANK_AW-1:0]           coeff_wa, coeff_ra;
	logic [COEFF_WIDTH-1:0]       coeff_wd;
	logic signed [31:0]           coeff_ext;

	// Handshake and datapath control.
	logic              accept, emit_acc, issue, load_out;
	logic              tap_valid_s1, tap_first_s1, tap_last_s1;
	mac_ctl_t          mac_ctl;
	logic              mac_done;
	logic [PIX_W-1:0]  mac_result;
	logic              res_valid_q, res_row_end_q;
	logic [PIX_W-1:0]  res_pixel_q;
	logic [OWID_W-1:0] next_cnt;
	logic              row_end_now;

	// Register port: always ready, register index from the word address.
	assign pready  = 1'b1;
	assign reg_idx = reg_index_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q      <= 4'd4;
			step_q      <= STEP_W'(32'h0001_0000);
			out_width_q <= OWID_W'(1);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_TAPS:      taps_q      <= pwdata[3:0];
				REG_STEP:      step_q      <= pwdata[STEP_W-1:0];
				REG_OUT_WIDTH: out_width_q <= pwdata[OWID_W-1:0];
				REG_NONE:      ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TAPS:      prdata = 32'(taps_q);
			REG_STEP:      prdata = 32'(step_q);
			REG_OUT_WIDTH: prdata = 32'(out_width_q);
			REG_NONE:      prdata = 32'd0;
		endcase
	end

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (emit_acc) state_d = ST_RUN;
			ST_RUN:  if (k_q == nt_q - TAPS_W'(1)) state_d = ST_WAIT;
			ST_WAIT: if (load_out) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		cmd.ready = 1'b0;
		issue     = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: cmd.ready = 1'b1;
			ST_RUN:  issue = 1'b1;
			ST_WAIT: load_out = mac_done && (!res_valid_q || res.ready);
			default: ;
		endcase
	end

	assign accept   = cmd.valid && cmd.ready;
	assign emit_acc = accept && (cmd.opcode == OP_EMIT);

	// Effective tap count: zero acts as one, above the maximum as the maximum.
	always_comb begin
		if (taps_q == 4'd0) begin
			nt_d = TAPS_W'(1);
		end else if (32'(taps_q) > MAX_TAPS) begin
			nt_d = TAPS_W'(MAX_TAPS);
		end else begin
			nt_d = TAPS_W'(taps_q);
		end
	end

	// Row-end check for the item being accepted.
	assign next_cnt    = OWID_W'(count_q) + OWID_W'(1);
	assign row_end_now = next_cnt >= out_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			count_q <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (accept && cmd.opcode == OP_SET_POS) begin
				pos_q   <= cmd.position;
				count_q <= '0;
			end else if (emit_acc) begin
				pos_q   <= pos_q + POS_W'(step_q);
				count_q <= row_end_now ? '0 : next_cnt[CNT_W-1:0];
			end
			if (emit_acc) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + TAPS_W'(1);
			end
		end
	end

	// Per-item read bases, latched when an emit item is taken.
	always_ff @(posedge clk) begin
		if (emit_acc) begin
			nt_q           <= nt_d;
			base_q         <= ROW_AW'(32'(pos_q[POS_W-1:16]) % ROW_LENGTH);
			cbase_q        <= BANK_AW'(pos_q[15:8]) * BANK_AW'(nt_d);
			row_end_pend_q <= row_end_now;
		end
	end

	// Store write and read addresses.
	assign coeff_ext = 32'(cmd.coefficient);
	assign coeff_wd  = coeff_ext[COEFF_WIDTH-1:0];
	assign coeff_we  = accept && cmd.opcode == OP_LOAD_COEFF
		&& 32'(cmd.address) < BANK_DEPTH;
	assign coeff_wa  = BANK_AW'(cmd.address);
	assign row_we    = accept && cmd.opcode == OP_LOAD_PIXEL;
	assign row_wa    = ROW_AW'(32'(cmd.address) % ROW_LENGTH);
	assign row_ra    = ROW_AW'((32'(base_q) + 32'(k_q)) % ROW_LENGTH);
	assign coeff_ra  = cbase_q + BANK_AW'(k_q);

	// Row store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[row_wa] <= cmd.pixel_in;
		end
		pix_rd_s1 <= row_mem[row_ra];
	end

	// Coefficient bank: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (coeff_we) begin
			coeff_mem[coeff_wa] <= coeff_wd;
		end
		coeff_rd_s1 <= coeff_mem[coeff_ra];
	end

	// Tap markers that line up with the read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_valid_s1 <= 1'b0;
			tap_first_s1 <= 1'b0;
			tap_last_s1  <= 1'b0;
		end else begin
			tap_valid_s1 <= issue;
			tap_first_s1 <= issue && k_q == '0;
			tap_last_s1  <= issue && k_q == nt_q - TAPS_W'(1);
		end
	end

	assign mac_ctl = '{start: emit_acc, valid: tap_valid_s1,
		first: tap_first_s1, last: tap_last_s1};

	hpr_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.pixel  (pix_rd_s1),
		.coeff  (signed'(coeff_rd_s1)),
		.done   (mac_done),
		.result (mac_result)
	);

	// Output register holds one finished item until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_pixel_q   <= mac_result;
			res_row_end_q <= row_end_pend_q;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.pixel_out = res_pixel_q;
	assign res.row_end   = res_row_end_q;

endmodule

// ===== sv/hpr_mac.sv =====
// Three-channel multiply-accumulate with rounding, shift and clamp.
// Depends on hpr_pkg for widths and the mac_ctl_t control struct.
module hpr_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  hpr_pkg::mac_ctl_t                     ctl,
	input  logic [hpr_pkg::PIX_W-1:0]             pixel,
	input  logic signed [hpr_pkg::COEFF_WIDTH-1:0] coeff,
	output logic                                  done,
	output logic [hpr_pkg::PIX_W-1:0]             result
);
	import hpr_pkg::*;

	logic signed [PROD_W-1:0] prod_s2 [3];
	logic                     valid_s2, first_s2, last_s2;
	logic signed [ACC_W-1:0]  acc_q [3];
	logic                     done_q;

	function automatic logic [7:0] clamp_ch(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] sh;
		sh = acc >>> FRAC_BITS;
		if (acc < 0) begin
			return 8'd0;
		end else if (|sh[ACC_W-1:8]) begin
			return 8'hff;
		end else begin
			return sh[7:0];
		end
	endfunction

	// Product stage: channel times coefficient, one register.
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			prod_s2[c] <= PROD_W'(signed'({1'b0, pixel[c*8 +: 8]})) * PROD_W'(coeff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			first_s2 <= 1'b0;
			last_s2  <= 1'b0;
		end else begin
			valid_s2 <= ctl.valid;
			first_s2 <= ctl.first;
			last_s2  <= ctl.last;
		end
	end

	// Accumulate; the first tap reloads from the rounding constant.
	always_ff @(posedge clk) begin
		if (valid_s2) begin
			for (int c = 0; c < 3; c++) begin
				if (first_s2) begin
					acc_q[c] <= ACC_W'(ROUND_INIT) + ACC_W'(prod_s2[c]);
				end else begin
					acc_q[c] <= acc_q[c] + ACC_W'(prod_s2[c]);
				end
			end
		end
	end

	// Done stays high from the last tap until the next item starts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (ctl.start) begin
			done_q <= 1'b0;
		end else if (valid_s2 && last_s2) begin
			done_q <= 1'b1;
		end
	end

	assign done   = done_q;
	assign result = {clamp_ch(acc_q[2]), clamp_ch(acc_q[1]), clamp_ch(acc_q[0])};

endmodule

// ===== sv/hpr_checker.sv =====
// Port-level checks for the resampler top level, and the bind that attaches them.
// Depends on hpr_pkg for the opcode codes.
module hpr_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input hpr_pkg::opcode_t in_opcode,
	input logic             out_valid,
	input logic             out_ready
);
	import hpr_pkg::*;

	// A waiting result stays offered until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped before it was taken");

	// An emit item occupies the block for at least the next cycle.
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_opcode == OP_EMIT |=> !in_ready)
		else $error("block took a new item right after an emit item");

	// Load and set-position items never cause a result.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_opcode != OP_EMIT && !out_valid |=> !out_valid)
		else $error("result appeared after a non-emit item");

	// A new result only shows up while the block is busy with an emit item.
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while the block was idle");

endmodule

bind horizontal_polyphase_resampler_unit hpr_checker u_hpr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (cmd.valid),
	.in_ready  (cmd.ready),
	.in_opcode (cmd.opcode),
	.out_valid (res.valid),
	.out_ready (res.ready)
);

// ===== bench/hpr_pixel_checker.sv =====
`timescale 1ns / 100ps
// Checker for the horizontal polyphase resampler: snoops the register port and both channels,
// predicts each emitted pixel item and compares it with what the block delivers.
// Depends on hpr_pkg and the channel interfaces in hpr_if.
module hpr_pixel_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	hpr_cmd_if                           cmd,
	hpr_res_if                           res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [hpr_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output int                           outstanding,
	output int                           fail_count
);
	import hpr_pkg::*;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             row_end;
	} pixel_item_t;

	// Shadow copies of the stores, the row state and the registers.
	logic signed [COEFF_WIDTH-1:0] coeff_bank [BANK_DEPTH];
	logic [PIX_W-1:0]              row_pixels [ROW_LENGTH];
	logic [POS_W-1:0]              src_position;
	logic [CNT_W-1:0]              column;
	logic [3:0]                    taps_reg;
	logic [STEP_W-1:0]             step_reg;
	logic [OWID_W-1:0]             width_reg;
	pixel_item_t                   pending_pixels [$];
	int                            mismatches;

	// Drop the fraction bits and clamp one channel sum to 0..255.
	function automatic logic [7:0] saturate_sum(int sum);
		int scaled;
		if (sum < 0)
			return 8'd0;
		scaled = sum >>> FRAC_BITS;
		return (scaled > 255) ? 8'hff : scaled[7:0];
	endfunction

	// Filter one output pixel at the current position, then advance the position and column.
	function automatic pixel_item_t filter_pixel();
		int               n_taps;
		int               base;
		int               phase;
		int               c;
		int               r;
		int               g;
		int               b;
		int               next_col;
		logic [PIX_W-1:0] src;
		pixel_item_t      item;
		n_taps = taps_reg;
		if (n_taps < 1)
			n_taps = 1;
		if (n_taps > MAX_TAPS)
			n_taps = MAX_TAPS;
		base  = src_position[27:16];
		phase = src_position[15:8];
		r = ROUND_INIT;
		g = ROUND_INIT;
		b = ROUND_INIT;
		for (int k = 0; k < n_taps; k++) begin
			src = row_pixels[(base + k) % ROW_LENGTH];
			c   = coeff_bank[phase * n_taps + k];
			r  += int'(src[23:16]) * c;
			g  += int'(src[15:8]) * c;
			b  += int'(src[7:0]) * c;
		end
		src_position = src_position + POS_W'(step_reg);
		item.pixel = {saturate_sum(r), saturate_sum(g), saturate_sum(b)};
		next_col = int'(column) + 1;
		if (next_col >= int'(width_reg)) begin
			item.row_end = 1'b1;
			column = '0;
		end else begin
			item.row_end = 1'b0;
			column = next_col[CNT_W-1:0];
		end
		return item;
	endfunction

	// Results are matched before new commands are taken, so an item never meets its own result.
	always @(posedge clk or negedge arst_n) begin
		pixel_item_t want;
		if (!arst_n) begin
			pending_pixels.delete();
			src_position = '0;
			column       = '0;
			taps_reg     = 4'd4;
			step_reg     = 24'h010000;
			width_reg    = 13'd1;
			mismatches   = 0;
			outstanding <= 0;
			fail_count  <= 0;
		end else begin
			// Compare each delivered pixel item with the oldest prediction.
			if (res.valid && res.ready) begin
				if (pending_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected pixel item: pixel_out %h row_end %b",
							res.pixel_out, res.row_end);
				end else begin
					want = pending_pixels.pop_front();
					if (res.pixel_out !== want.pixel || res.row_end !== want.row_end) begin
						mismatches++;
						if (mismatches <= 10)
							$display("pixel mismatch: expected %h/%b, got %h/%b",
								want.pixel, want.row_end, res.pixel_out, res.row_end);
					end
				end
			end

			// Track register writes.
			if (psel && penable && pwrite && pready) begin
				case (reg_index_t'(paddr[3:2]))
					REG_TAPS:      taps_reg  = pwdata[3:0];
					REG_STEP:      step_reg  = pwdata[STEP_W-1:0];
					REG_OUT_WIDTH: width_reg = pwdata[OWID_W-1:0];
					default: ;
				endcase
			end

			// Apply each accepted command item.
			if (cmd.valid && cmd.ready) begin
				case (cmd.opcode)
					OP_LOAD_COEFF: begin
						if (cmd.address < BANK_DEPTH)
							coeff_bank[cmd.address] = cmd.coefficient;
					end
					OP_LOAD_PIXEL: row_pixels[cmd.address % ROW_LENGTH] = cmd.pixel_in;
					OP_SET_POS: begin
						src_position = cmd.position;
						column       = '0;
					end
					OP_EMIT: pending_pixels.push_back(filter_pixel());
					default: ;
				endcase
			end

			outstanding <= pending_pixels.size();
			fail_count  <= mismatches;
		end
	end

endmodule

// ===== bench/horizontal_polyphase_resampler_unit_test.sv =====
`timescale 1ns / 100ps
// Top of the resampler testbench: clock, reset, register writes, command and result idling.
// Depends on hpr_pkg, hpr_if, the block itself and hpr_pixel_checker, which gives the fail count.
module horizontal_polyphase_resampler_unit_test;
	import hpr_pkg::*;

	localparam int ITEM_TARGET   = 1700;
	localparam int CALM_TAIL     = 250;
	localparam int SETTLE_CYCLES = 16;
	localparam int LONG_HOLD     = 300;
	localparam int RESET_CYCLES  = 5;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	int                 outstanding;
	int                 fail_count;

	hpr_cmd_if cmd_ch();
	hpr_res_if res_ch();

	// What the stimulus knows about the block, used to avoid reading unwritten entries.
	bit                coeff_loaded [BANK_DEPTH];
	bit                pixel_loaded [ROW_LENGTH];
	logic [POS_W-1:0]  plan_pos   = '0;
	logic [3:0]        plan_taps  = 4'd4;
	logic [STEP_W-1:0] plan_step  = 24'h010000;
	logic [OWID_W-1:0] plan_width = 13'd1;
	int                items_sent   = 0;
	bit                calm         = 1'b0;
	int                holds_wanted = 0;
	int                holds_done   = 0;

	always #1 clk = ~clk;

	horizontal_polyphase_resampler_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	hpr_pixel_checker watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.res         (res_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	// Coefficients: mostly moderate values so outputs land inside 0..255, some at full range.
	function automatic logic [15:0] pick_coeff(bit extreme);
		int roll;
		roll = $urandom_range(0, 99);
		if (extreme) begin
			case ($urandom_range(0, 4))
				0: return 16'h7fff;
				1: return 16'h8000;
				2: return 16'h0000;
				3: return 16'h4000;
				default: return 16'hffff;
			endcase
		end
		if (roll < 60)
			return 16'($urandom_range(0, 7500) - 1500);
		if (roll < 85)
			return 16'($urandom_range(0, 20000) - 4000);
		return 16'($urandom);
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel(bit extreme);
		if (extreme) begin
			case ($urandom_range(0, 4))
				0: return 24'h000000;
				1: return 24'hffffff;
				2: return 24'hff0000;
				3: return 24'h00ff00;
				default: return 24'h0000ff;
			endcase
		end
		return 24'($urandom);
	endfunction

	// Offer one command item and hold it until accepted, then maybe leave a gap.
	task automatic send_item(opcode_t op, logic [ADDR_W-1:0] addr, logic [15:0] coeff,
		logic [PIX_W-1:0] pix, logic [POS_W-1:0] pos);
		cmd_ch.valid       <= 1'b1;
		cmd_ch.opcode      <= op;
		cmd_ch.address     <= addr;
		cmd_ch.coefficient <= coeff;
		cmd_ch.pixel_in    <= pix;
		cmd_ch.position    <= pos;
		do @(posedge clk); while (!cmd_ch.ready);
		if (!(op == OP_LOAD_COEFF && addr >= BANK_DEPTH))
			items_sent++;
		if (!calm && $urandom_range(0, 5) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic load_coeff(int addr, logic [15:0] value);
		send_item(OP_LOAD_COEFF, addr[ADDR_W-1:0], value, 24'($urandom), 28'($urandom));
		if (addr < BANK_DEPTH)
			coeff_loaded[addr] = 1'b1;
	endtask

	task automatic load_pixel(int addr, logic [PIX_W-1:0] value);
		send_item(OP_LOAD_PIXEL, addr[ADDR_W-1:0], 16'($urandom), value, 28'($urandom));
		pixel_loaded[addr % ROW_LENGTH] = 1'b1;
	endtask

	task automatic set_position(logic [POS_W-1:0] pos);
		send_item(OP_SET_POS, 12'($urandom), 16'($urandom), 24'($urandom), pos);
		plan_pos = pos;
	endtask

	// Load whatever this output pixel would read that is still unwritten, then emit it.
	task automatic emit_pixel(bit extreme);
		int n_taps;
		int base;
		int phase;
		int ci;
		int pi;
		n_taps = plan_taps;
		if (n_taps < 1)
			n_taps = 1;
		if (n_taps > MAX_TAPS)
			n_taps = MAX_TAPS;
		base  = plan_pos[27:16];
		phase = plan_pos[15:8];
		for (int k = 0; k < n_taps; k++) begin
			ci = phase * n_taps + k;
			pi = (base + k) % ROW_LENGTH;
			if (!coeff_loaded[ci])
				load_coeff(ci, pick_coeff(extreme));
			if (!pixel_loaded[pi])
				load_pixel(pi, pick_pixel(extreme));
		end
		send_item(OP_EMIT, 12'($urandom), 16'($urandom), 24'($urandom), 28'($urandom));
		plan_pos = plan_pos + POS_W'(plan_step);
	endtask

	// Stop offering items and wait until every predicted pixel has come back.
	task automatic wait_for_drain();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all three registers while the block is idle; upper data bits carry junk.
	task automatic configure(logic [3:0] t, logic [STEP_W-1:0] s, logic [OWID_W-1:0] w);
		logic [31:0] values [3];
		reg_index_t  regs [3];
		values[0] = {28'($urandom), t};
		values[1] = {8'($urandom), s};
		values[2] = {19'($urandom), w};
		regs[0] = REG_TAPS;
		regs[1] = REG_STEP;
		regs[2] = REG_OUT_WIDTH;
		wait_for_drain();
		for (int i = 0; i < 3; i++) begin
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b1;
			paddr   <= {regs[i], 2'b00};
			pwdata  <= values[i];
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		plan_taps  = t;
		plan_step  = s;
		plan_width = w;
	endtask

	// Result side: random ready bursts, one long hold on request, none in the calm tail.
	initial begin
		int span;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (holds_wanted > holds_done) begin
				res_ch.ready <= 1'b0;
				span = LONG_HOLD;
				holds_done++;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				res_ch.ready <= 1'b0;
				span = $urandom_range(1, 4);
			end else begin
				res_ch.ready <= 1'b1;
				span = calm ? 1 : $urandom_range(1, 12);
			end
			repeat (span) @(posedge clk);
		end
	end

	// Command side and verdict.
	initial begin
		int               rows;
		int               emits;
		logic [3:0]       t;
		logic [STEP_W-1:0] s;
		logic [OWID_W-1:0] w;
		logic [POS_W-1:0] start;
		arst_n             <= 1'b0;
		psel               <= 1'b0;
		penable            <= 1'b0;
		pwrite             <= 1'b0;
		paddr              <= '0;
		pwdata             <= '0;
		cmd_ch.valid       <= 1'b0;
		cmd_ch.opcode      <= OP_LOAD_COEFF;
		cmd_ch.address     <= '0;
		cmd_ch.coefficient <= '0;
		cmd_ch.pixel_in    <= '0;
		cmd_ch.position    <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme coefficients and pixels at the reset position and settings.
		load_coeff(0, 16'h7fff);
		load_coeff(1, 16'h8000);
		load_coeff(2, 16'h4000);
		load_coeff(3, 16'h0000);
		load_pixel(0, 24'hffffff);
		load_pixel(1, 24'h000000);
		load_pixel(2, 24'h80ff01);
		load_pixel(3, 24'hffffff);
		emit_pixel(1'b1);
		emit_pixel(1'b1);
		// Coefficient loads past the end of the bank are dropped.
		load_coeff(BANK_DEPTH, 16'h1234);
		load_coeff(4095, 16'hffff);
		// Highest position: last phase, taps wrap around the row end.
		load_pixel(ROW_LENGTH - 1, 24'hffffff);
		set_position(28'hfffffff);
		emit_pixel(1'b1);
		// Zero taps act as one, zero step holds the position, zero width acts as one.
		configure(4'd0, 24'd0, 13'd0);
		emit_pixel(1'b1);
		emit_pixel(1'b1);

		// Random rows: mostly well-formed position/emit sequences with stray items mixed in.
		rows = 0;
		while (items_sent < ITEM_TARGET) begin
			case (rows)
				0: configure(4'd15, 24'hffffff, 13'd8191);
				1: configure(4'd8, 24'h010000, 13'd4096);
				2: configure(4'd1, 24'd1, 13'd1);
				default: begin
					if (!calm && $urandom_range(0, 3) == 0) begin
						case ($urandom_range(0, 6))
							0:       t = 4'd0;
							1:       t = 4'($urandom_range(9, 15));
							default: t = 4'($urandom_range(1, 8));
						endcase
						case ($urandom_range(0, 9))
							0:       s = '0;
							1:       s = 24'hffffff;
							2, 3:    s = 24'($urandom);
							default: s = 24'($urandom_range(16384, 262144));
						endcase
						case ($urandom_range(0, 9))
							0:       w = 13'd0;
							1:       w = 13'd4096;
							2:       w = 13'd8191;
							3:       w = 13'($urandom_range(13, 300));
							default: w = 13'($urandom_range(1, 12));
						endcase
						configure(t, s, w);
					end
				end
			endcase
			calm = (items_sent >= ITEM_TARGET - CALM_TAIL);

			if ($urandom_range(0, 9) != 0) begin
				if ($urandom_range(0, 6) == 0)
					start = 28'($urandom);
				else
					start = {12'($urandom_range(0, 48)), 16'($urandom)};
				set_position(start);
			end

			if (plan_width >= 1 && plan_width <= 12)
				emits = $urandom_range(1, 2 * plan_width + 1);
			else
				emits = $urandom_range(1, 30);
			// Once, hold off the result side long enough for the block to back up.
			if (holds_wanted == 0 && items_sent > 500) begin
				holds_wanted = 1;
				emits = 24;
			end

			repeat (emits) begin
				if ($urandom_range(0, 7) == 0) begin
					case ($urandom_range(0, 2))
						0:       load_coeff($urandom_range(0, 4095), pick_coeff(1'b0));
						1:       load_pixel($urandom_range(0, 4095), pick_pixel(1'b0));
						default: set_position(28'($urandom));
					endcase
				end
				emit_pixel(1'b0);
			end
			rows++;
		end

		wait_for_drain();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Give up if the run hangs.
	initial begin
		#1000000;
		$display("FAILURE");
		$finish;
	end

endmodule
